>>> hw/rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and slot helpers for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

	// Store depth and derived widths
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = 5;
	localparam int VAL_W = 32;

	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	// Operation codes; codes above OP_STATUS act as a status read
	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_STATUS     = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]              operation;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] front_value;
		logic signed [VAL_W-1:0] rear_value;
		logic                    ends_valid;
		logic [CNT_W-1:0]        element_count;
		logic                    is_empty;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
		logic load;
	} dq_cmd_t;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

endpackage

>>> hw/rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Sequencing: capture, update, store read and result load, in that order;
// the result load waits while the output register still holds a result.
// A new transaction is taken only after the previous one has been loaded.
// Reset: pointers and count cleared, capacity back to 16; the store is not
// cleared (entries are written before they are read), so no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_top (
	input  logic                      clk,
	input  logic                      arst_n,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  dq_pkg::in_item_t          in_item,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output dq_pkg::out_item_t         out_item,
	// capacity register
	input  logic                      cfg_we,
	input  logic [dq_pkg::CNT_W-1:0]  cfg_wdata
);

	// Command bundle from sequencer to datapath:
	//   capture - latch the incoming transaction
	//   exec    - apply the operation: pointers, count, status, store write
	//   read    - read front and rear entries into registers
	//   load    - move the finished result into the output register
	dq_pkg::dq_cmd_t cmd;

	// The output register decouples the two sides: a new transaction is
	// accepted while the previous result still waits for out_ready.
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Circular store: push front steps head back, push back writes at tail.
	// Pushes overflow once the count reaches the capacity (clamped to depth).
	dq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_item  (out_item)
	);

endmodule

>>> hw/rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one transaction at a time and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dq_pkg::dq_cmd_t   cmd
);

	dq_pkg::state_t state_q, state_d;
	logic           out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.load | (out_valid_q & ~out_ready);
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			dq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = dq_pkg::S_EXEC;
				end
			end
			dq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = dq_pkg::S_READ;
			end
			dq_pkg::S_READ: begin
				cmd.read = 1'b1;
				state_d  = dq_pkg::S_LOAD;
			end
			dq_pkg::S_LOAD: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = dq_pkg::S_IDLE;
				end
			end
			default: state_d = dq_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> hw/rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Pointers, count, capacity register, circular store and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dq_pkg::dq_cmd_t           cmd,
	input  dq_pkg::in_item_t          in_item,
	input  logic                      cfg_we,
	input  logic [dq_pkg::CNT_W-1:0]  cfg_wdata,
	output dq_pkg::out_item_t         out_item
);

	logic [2:0]                     op_q;
	logic [dq_pkg::VAL_W-1:0]       val_q;
	logic [dq_pkg::CNT_W-1:0]       cap_q;
	logic [dq_pkg::IDX_W-1:0]       head_q, tail_q;
	logic [dq_pkg::CNT_W-1:0]       count_q;
	logic [1:0]                     status_q;
	logic [dq_pkg::VAL_W-1:0]       mem [dq_pkg::DEPTH];
	logic [dq_pkg::VAL_W-1:0]       front_rd_q, rear_rd_q;
	dq_pkg::out_item_t              result_q;

	logic [dq_pkg::CNT_W-1:0]       cap_eff;
	logic [dq_pkg::IDX_W-1:0]       head_d, tail_d, wr_addr;
	logic [dq_pkg::CNT_W-1:0]       count_d;
	logic [1:0]                     status_d;
	logic                           wr_en;

	assign cap_eff = (cap_q > dq_pkg::DEPTH_C) ? dq_pkg::DEPTH_C : cap_q;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = dq_pkg::ST_OK;
		wr_addr  = tail_q;
		wr_en    = 1'b0;
		case (op_q) inside
			dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
				if (count_q >= cap_eff) begin
					status_d = dq_pkg::ST_OVERFLOW;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + dq_pkg::CNT_W'(1);
					if (op_q == dq_pkg::OP_PUSH_FRONT) begin
						head_d  = dq_pkg::prev_slot(head_q);
						wr_addr = head_d;
					end else begin
						tail_d  = dq_pkg::next_slot(tail_q);
					end
				end
			end
			dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
				if (count_q == '0) begin
					status_d = dq_pkg::ST_UNDERFLOW;
				end else begin
					count_d = count_q - dq_pkg::CNT_W'(1);
					if (op_q == dq_pkg::OP_POP_FRONT) begin
						head_d = dq_pkg::next_slot(head_q);
					end else begin
						tail_d = dq_pkg::prev_slot(tail_q);
					end
				end
			end
			default: ; // status read
		endcase
	end

	// transaction payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_item.operation;
			val_q <= in_item.value;
		end
		if (cmd.exec) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= dq_pkg::CAP_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
		end
	end

	// store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.read) begin
			front_rd_q <= mem[head_q];
			rear_rd_q  <= mem[dq_pkg::prev_slot(tail_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result_q.status        <= status_q;
			result_q.element_count <= count_q;
			if (count_q != '0) begin
				result_q.front_value <= front_rd_q;
				result_q.rear_value  <= rear_rd_q;
				result_q.ends_valid  <= 1'b1;
				result_q.is_empty    <= 1'b0;
			end else begin
				result_q.front_value <= '0;
				result_q.rear_value  <= '0;
				result_q.ends_valid  <= 1'b0;
				result_q.is_empty    <= 1'b1;
			end
		end
	end

	assign out_item = result_q;

endmodule

>>> hw/rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input dq_pkg::out_item_t         out_item
);

	// one transaction in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction is in flight");

	// empty flag agrees with count and ends flag
	a_empty_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.is_empty == (out_item.element_count == '0)) &&
			(out_item.ends_valid == !out_item.is_empty))
		else $error("empty, count and ends flags disagree");

	// empty result shows zero end values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_empty |->
			out_item.front_value == '0 && out_item.rear_value == '0)
		else $error("empty result with nonzero end values");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
